>>> hw/rtl/lds_pkg.sv
package lds_pkg;

  localparam int DEF_POOL_NODES   = 64;
  localparam int DEF_PAYLOAD_BITS = 32;
  localparam int DEF_KEY_BITS     = 32;

  localparam int OP_W     = 3;
  localparam int HANDLE_W = 6;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_REMOVE,
    OP_SORT,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL,
    ST_BAD_HANDLE
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_WAIT,
    S_TGT_WAIT,
    S_PREV_WAIT,
    S_NEXT_WAIT,
    S_SRT_CUR,
    S_SRT_NX,
    S_SRT_SW2,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/lds_ram.sv
module lds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/lds_free_find.sv
module lds_free_find #(
  parameter int N = 2
) (
  input  logic [N-1:0]         used,
  output logic                 found,
  output logic [$clog2(N)-1:0] idx
);

  // lowest free entry wins
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        idx = ($clog2(N))'(i);
      end
    end
    found = ~&used;
  end

endmodule

>>> hw/rtl/linked_deque_with_sort_top.sv
// Doubly linked deque in a pool of POOL_NODES nodes, each holding a payload and a sort key.
// One op is taken per transfer on the op channel (push front/back, pop front/back, remove,
// read, sort) and each op gives exactly one result transfer, which always carries the list's
// count, head and tail. Links live in one single-port-read RAM and payload/key in another,
// both with a registered read, so every op walks a short sequence of read-modify-write
// steps: a push into an empty list or any flagged op goes straight to the result, other
// pushes add a step that relinks the old end node, read adds one that fetches the node,
// and pop and remove add that fetch plus one step per neighbor that must be relinked. Sort
// is bubble passes that swap payload and key between neighbors, never links, until a pass
// makes no swap. The op channel is stalled for the whole op; a finished result waits in
// the output register so the next op can start; only the final step holds while it is full.
module linked_deque_with_sort_top
  import lds_pkg::*;
#(
  parameter int POOL_NODES   = DEF_POOL_NODES,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
  parameter int KEY_BITS     = DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [WORD_W-1:0]   payload,
  input  logic [WORD_W-1:0]   sort_key,
  input  logic [HANDLE_W-1:0] node_handle,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [1:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic [WORD_W-1:0]   data_out,
  output logic [WORD_W-1:0]   key_out,
  output logic [HANDLE_W-1:0] next_handle,
  output logic                has_next,
  output logic [HANDLE_W-1:0] prev_handle,
  output logic                has_prev,
  output logic [COUNT_W-1:0]  item_count,
  output logic [HANDLE_W-1:0] first_handle,
  output logic [HANDLE_W-1:0] last_handle,
  output logic                nonempty
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);
  // link word: {next, next valid, prev, prev valid}
  localparam int LW = 2 * NW + 2;
  // data word: {payload, key}
  localparam int DW = PAYLOAD_BITS + KEY_BITS;

  state_t state, state_next;

  // list bookkeeping
  logic [NW-1:0]         head, head_next, tail, tail_next;
  logic [CW-1:0]         count, count_next;
  logic [POOL_NODES-1:0] in_use, in_use_next;

  // op context
  op_t                   op_r, op_r_next;
  logic [NW-1:0]         tgt, tgt_next;      // node being pushed, popped, removed or read
  logic [NW-1:0]         nbr, nbr_next;      // neighbor touched by a push
  logic [LW-1:0]         tlink, tlink_next;  // links of the node being unlinked

  // sort walk
  logic [NW-1:0]         cur, cur_next, nx, nx_next;
  logic [DW-1:0]         cd, cd_next;
  logic                  held, held_next, swapped, swapped_next;

  // result being built
  status_t               r_status, r_status_next;
  logic [NW-1:0]         r_handle, r_handle_next, r_nh, r_nh_next, r_ph, r_ph_next;
  logic                  r_hn, r_hn_next, r_hp, r_hp_next;
  logic [PAYLOAD_BITS-1:0] r_data, r_data_next;
  logic [KEY_BITS-1:0]   r_key, r_key_next;

  // memory ports
  logic          link_we, data_we;
  logic [NW-1:0] link_wa, link_ra, data_wa, data_ra;
  logic [LW-1:0] link_wd, link_rd;
  logic [DW-1:0] data_wd, data_rd;

  logic          free_found;
  logic [NW-1:0] free_idx;

  logic          accept, handle_ok, push_front, res_load;
  logic [NW-1:0] hidx, cdv_dummy;
  logic [DW-1:0] cdv;

  // link word fields of the read port
  logic [NW-1:0] l_next, l_prev, t_next, t_prev;
  logic          l_nv, l_pv, t_nv, t_pv;

  assign l_next = link_rd[LW-1 -: NW];
  assign l_nv   = link_rd[NW+1];
  assign l_prev = link_rd[NW:1];
  assign l_pv   = link_rd[0];
  assign t_next = tlink[LW-1 -: NW];
  assign t_nv   = tlink[NW+1];
  assign t_prev = tlink[NW:1];
  assign t_pv   = tlink[0];

  assign op_stall   = (state != S_IDLE);
  assign accept     = op_valid && !op_stall;
  assign hidx       = NW'(node_handle);
  assign handle_ok  = (32'(node_handle) < POOL_NODES) && in_use[hidx];
  assign push_front = (op_r == OP_PUSH_FRONT);
  assign res_load   = (state == S_DONE) && (!res_valid || !res_stall);
  assign cdv        = held ? cd : data_rd;
  assign cdv_dummy  = '0;

  lds_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_wa),
    .wdata (link_wd),
    .raddr (link_ra),
    .rdata (link_rd)
  );

  lds_ram #(.WIDTH(DW), .DEPTH(POOL_NODES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_wa),
    .wdata (data_wd),
    .raddr (data_ra),
    .rdata (data_rd)
  );

  lds_free_find #(.N(POOL_NODES)) u_free_find (
    .used  (in_use),
    .found (free_found),
    .idx   (free_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          case (op_t'(op))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (free_found && count != '0) state_next = S_PUSH_WAIT;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count != '0) state_next = S_TGT_WAIT;
            end
            OP_REMOVE, OP_READ: begin
              if (handle_ok) state_next = S_TGT_WAIT;
            end
            OP_SORT: begin
              if (count > CW'(1)) state_next = S_SRT_CUR;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PUSH_WAIT: state_next = S_DONE;
      S_TGT_WAIT: begin
        if (op_r == OP_READ) state_next = S_DONE;
        else if (l_pv)       state_next = S_PREV_WAIT;
        else if (l_nv)       state_next = S_NEXT_WAIT;
        else                 state_next = S_DONE;
      end
      S_PREV_WAIT: state_next = t_nv ? S_NEXT_WAIT : S_DONE;
      S_NEXT_WAIT: state_next = S_DONE;
      S_SRT_CUR: begin
        if (l_nv)         state_next = S_SRT_NX;
        else if (swapped) state_next = S_SRT_CUR;
        else              state_next = S_DONE;
      end
      S_SRT_NX: begin
        if (cd[KEY_BITS-1:0] < data_rd[KEY_BITS-1:0]) state_next = S_SRT_SW2;
        else                                           state_next = S_SRT_CUR;
      end
      S_SRT_SW2: state_next = S_SRT_CUR;
      S_DONE:    state_next = res_load ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory controls and datapath updates
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    in_use_next   = in_use;
    op_r_next     = op_r;
    tgt_next      = tgt;
    nbr_next      = nbr;
    tlink_next    = tlink;
    cur_next      = cur;
    nx_next       = nx;
    cd_next       = cd;
    held_next     = held;
    swapped_next  = swapped;
    r_status_next = r_status;
    r_handle_next = r_handle;
    r_data_next   = r_data;
    r_key_next    = r_key;
    r_nh_next     = r_nh;
    r_hn_next     = r_hn;
    r_ph_next     = r_ph;
    r_hp_next     = r_hp;
    link_we = 1'b0;
    link_wa = '0;
    link_wd = '0;
    link_ra = '0;
    data_we = 1'b0;
    data_wa = '0;
    data_wd = '0;
    data_ra = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next     = op_t'(op);
          r_status_next = ST_OK;
          r_handle_next = '0;
          r_data_next   = '0;
          r_key_next    = '0;
          r_nh_next     = '0;
          r_hn_next     = 1'b0;
          r_ph_next     = '0;
          r_hp_next     = 1'b0;
          case (op_t'(op))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (!free_found) begin
                r_status_next = ST_FULL;
              end else begin
                tgt_next              = free_idx;
                r_handle_next         = free_idx;
                in_use_next[free_idx] = 1'b1;
                count_next            = count + CW'(1);
                data_we = 1'b1;
                data_wa = free_idx;
                data_wd = {PAYLOAD_BITS'(payload), KEY_BITS'(sort_key)};
                link_we = 1'b1;
                link_wa = free_idx;
                if (op_t'(op) == OP_PUSH_FRONT) begin
                  link_wd   = {head, count != '0, cdv_dummy, 1'b0};
                  nbr_next  = head;
                  link_ra   = head;
                  head_next = free_idx;
                  if (count == '0) tail_next = free_idx;
                end else begin
                  link_wd   = {cdv_dummy, 1'b0, tail, count != '0};
                  nbr_next  = tail;
                  link_ra   = tail;
                  tail_next = free_idx;
                  if (count == '0) head_next = free_idx;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count == '0) begin
                r_status_next = ST_EMPTY;
              end else begin
                tgt_next = (op_t'(op) == OP_POP_FRONT) ? head : tail;
                link_ra  = tgt_next;
                data_ra  = tgt_next;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (!handle_ok) begin
                r_status_next = ST_BAD_HANDLE;
              end else begin
                tgt_next = hidx;
                link_ra  = hidx;
                data_ra  = hidx;
              end
            end
            OP_SORT: begin
              cur_next     = head;
              held_next    = 1'b0;
              swapped_next = 1'b0;
              link_ra      = head;
              data_ra      = head;
            end
            default: begin
            end
          endcase
        end
      end

      S_PUSH_WAIT: begin
        // hook the old end node to the new one
        link_we = 1'b1;
        link_wa = nbr;
        if (push_front) link_wd = {l_next, l_nv, tgt, 1'b1};
        else            link_wd = {tgt, 1'b1, l_prev, l_pv};
      end

      S_TGT_WAIT: begin
        r_handle_next = tgt;
        r_data_next   = data_rd[DW-1 -: PAYLOAD_BITS];
        r_key_next    = data_rd[KEY_BITS-1:0];
        tlink_next    = link_rd;
        if (op_r == OP_READ) begin
          r_nh_next = l_nv ? l_next : '0;
          r_hn_next = l_nv;
          r_ph_next = l_pv ? l_prev : '0;
          r_hp_next = l_pv;
        end else begin
          in_use_next[tgt] = 1'b0;
          count_next       = count - CW'(1);
          if (!l_pv) head_next = l_next;
          if (!l_nv) tail_next = l_prev;
          if (count == CW'(1)) begin
            head_next = '0;
            tail_next = '0;
          end
          if (l_pv)      link_ra = l_prev;
          else if (l_nv) link_ra = l_next;
        end
      end

      S_PREV_WAIT: begin
        link_we = 1'b1;
        link_wa = t_prev;
        link_wd = {t_next, t_nv, l_prev, l_pv};
        link_ra = t_next;
      end

      S_NEXT_WAIT: begin
        link_we = 1'b1;
        link_wa = t_next;
        link_wd = {l_next, l_nv, t_prev, t_pv};
      end

      S_SRT_CUR: begin
        cd_next = cdv;
        if (l_nv) begin
          nx_next = l_next;
          data_ra = l_next;
        end else if (swapped) begin
          // another pass from the head
          cur_next     = head;
          held_next    = 1'b0;
          swapped_next = 1'b0;
          link_ra      = head;
          data_ra      = head;
        end
      end

      S_SRT_NX: begin
        if (cd[KEY_BITS-1:0] < data_rd[KEY_BITS-1:0]) begin
          data_we      = 1'b1;
          data_wa      = cur;
          data_wd      = data_rd;
          swapped_next = 1'b1;
        end else begin
          cd_next   = data_rd;
          held_next = 1'b1;
          cur_next  = nx;
          link_ra   = nx;
        end
      end

      S_SRT_SW2: begin
        // cd still holds cur's old payload and key, which nx now takes
        data_we   = 1'b1;
        data_wa   = nx;
        data_wd   = cd;
        held_next = 1'b1;
        cur_next  = nx;
        link_ra   = nx;
      end

      S_DONE: begin
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      in_use    <= '0;
      res_valid <= 1'b0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      count  <= count_next;
      in_use <= in_use_next;
      if (res_load)       res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    tgt      <= tgt_next;
    nbr      <= nbr_next;
    tlink    <= tlink_next;
    cur      <= cur_next;
    nx       <= nx_next;
    cd       <= cd_next;
    held     <= held_next;
    swapped  <= swapped_next;
    r_status <= r_status_next;
    r_handle <= r_handle_next;
    r_data   <= r_data_next;
    r_key    <= r_key_next;
    r_nh     <= r_nh_next;
    r_hn     <= r_hn_next;
    r_ph     <= r_ph_next;
    r_hp     <= r_hp_next;
    if (res_load) begin
      status       <= r_status;
      handle_out   <= HANDLE_W'(r_handle);
      data_out     <= WORD_W'(r_data);
      key_out      <= WORD_W'(r_key);
      next_handle  <= HANDLE_W'(r_nh);
      has_next     <= r_hn;
      prev_handle  <= HANDLE_W'(r_ph);
      has_prev     <= r_hp;
      item_count   <= COUNT_W'(count);
      first_handle <= (count != '0) ? HANDLE_W'(head) : '0;
      last_handle  <= (count != '0) ? HANDLE_W'(tail) : '0;
      nonempty     <= (count != '0);
    end
  end

`ifndef SYNTHESIS
  // count tracks the pool's in-use bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(in_use) == 32'(count)))
    else $error("node count differs from in-use bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= POOL_NODES)
    else $error("node count above pool size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("op accepted without producing a result");

  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    res_load |=> res_valid)
    else $error("result load lost");
`endif

endmodule
